// ===== design/fmipf_pkg.sv =====
// Shared types, codes and helpers for the first-match IPv4 prefix filter.
// No dependencies; every other design file but fmipf_ram refers to this package by scope.
`default_nettype none

package fmipf_pkg;

    // Field widths fixed by the item format
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 6;

    // Default table size
    localparam int RULE_CAPACITY = 64;

    // Item kind codes
    localparam logic KIND_RULE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Item as it travels from front end to back end
    typedef struct packed {
        logic              kind;
        logic              allows;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // One stored rule
    typedef struct packed {
        logic              allows;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] prefix;
    } rule_t;

    // Leading-ones mask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0)
        begin
            mask = '0;
        end
        else
        begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== design/fmipf_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module fmipf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled; read data is registered and shows the old contents on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== design/fmipf_front.sv =====
// Front end: accepts items, clamps the prefix length and masks rule addresses.
// Depends on fmipf_pkg.
`default_nettype none

module fmipf_front (
    input  wire logic                           start,
    input  wire logic                           kind,
    input  wire logic                           rule_allows,
    input  wire logic [fmipf_pkg::ADDR_W-1:0]   address,
    input  wire logic [fmipf_pkg::LEN_W-1:0]    prefix_length,
    input  wire logic                           q_full,
    output logic                                busy,
    output logic                                push,
    output fmipf_pkg::cmd_t                     cmd
);

    logic [fmipf_pkg::LEN_W-1:0] len_sat;

    // Lengths above 32 become exact host matches
    always_comb
    begin
        if (prefix_length > fmipf_pkg::LEN_W'(fmipf_pkg::ADDR_W))
        begin
            len_sat = fmipf_pkg::LEN_W'(fmipf_pkg::ADDR_W);
        end
        else
        begin
            len_sat = prefix_length;
        end
    end

    // Classify and normalize the item
    always_comb
    begin
        cmd.kind   = kind;
        cmd.allows = rule_allows;
        cmd.len    = len_sat;
        if (kind == fmipf_pkg::KIND_RULE)
        begin
            cmd.addr = address & fmipf_pkg::prefix_mask(len_sat);
        end
        else
        begin
            cmd.addr = address;
        end
    end

    assign busy = q_full;
    assign push = start & ~q_full;

endmodule

`default_nettype wire

// ===== design/fmipf_queue.sv =====
// Two-entry item queue between front end and back end.
// Depends on fmipf_pkg.
`default_nettype none

module fmipf_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fmipf_pkg::cmd_t push_cmd,
    input  wire logic            pop,
    output fmipf_pkg::cmd_t      head,
    output logic                 empty,
    output logic                 full
);

    fmipf_pkg::cmd_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] level_reg;
    logic [1:0] level_next;

    assign empty = (level_reg == 2'd0);
    assign full  = (level_reg == 2'd2);
    assign head  = entries_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/fmipf_back.sv =====
// Back end: appends rules to the table and scans it one rule per cycle for queries.
// Depends on fmipf_pkg and fmipf_ram.
`default_nettype none

module fmipf_back #(
    parameter int RULE_CAPACITY = fmipf_pkg::RULE_CAPACITY
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fmipf_pkg::cmd_t                head,
    input  wire logic                           q_empty,
    output logic                                pop,
    output logic                                done,
    output logic                                allowed,
    output logic                                rule_matched,
    output logic [fmipf_pkg::IDX_W-1:0]         matching_rule
);

    localparam int IW    = (RULE_CAPACITY > 1) ? $clog2(RULE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(RULE_CAPACITY + 1);
    localparam int RW    = $bits(fmipf_pkg::rule_t);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              iss_reg;
    logic [CNT_W-1:0]              iss_next;
    logic [IW-1:0]                 cmp_reg;
    logic [IW-1:0]                 cmp_next;
    logic                          dv_reg;
    logic                          dv_next;
    logic [fmipf_pkg::ADDR_W-1:0]  qaddr_reg;
    logic [fmipf_pkg::ADDR_W-1:0]  qaddr_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          allowed_reg;
    logic                          allowed_next;
    logic                          matched_reg;
    logic                          matched_next;
    logic [fmipf_pkg::IDX_W-1:0]   idx_reg;
    logic [fmipf_pkg::IDX_W-1:0]   idx_next;

    logic                          ram_we;
    logic [IW-1:0]                 ram_addr;
    fmipf_pkg::rule_t              ram_wdata;
    logic [RW-1:0]                 ram_rdata;
    fmipf_pkg::rule_t              rd_rule;
    logic                          hit;
    logic                          last;

    // Rule table
    fmipf_ram #(
        .WIDTH (RW),
        .DEPTH (RULE_CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_rule   = fmipf_pkg::rule_t'(ram_rdata);
    assign ram_wdata = '{allows: head.allows, len: head.len, prefix: head.addr};

    // Compare of the rule read last cycle
    assign hit  = ((qaddr_reg & fmipf_pkg::prefix_mask(rd_rule.len)) == rd_rule.prefix);
    assign last = ((CNT_W'(cmp_reg) + CNT_W'(1)) == count_reg);

    // Control
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        cmp_next     = cmp_reg;
        dv_next      = 1'b0;
        qaddr_next   = qaddr_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        matched_next = matched_reg;
        idx_next     = idx_reg;
        ram_we       = 1'b0;
        ram_addr     = count_reg[IW-1:0];
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (head.kind == fmipf_pkg::KIND_RULE)
                    begin
                        // full table drops the rule
                        if (count_reg < CNT_W'(RULE_CAPACITY))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        qaddr_next = head.addr;
                        if (count_reg == '0)
                        begin
                            done_next    = 1'b1;
                            allowed_next = 1'b1;
                            matched_next = 1'b0;
                            idx_next     = '0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            iss_next   = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                ram_addr = iss_reg[IW-1:0];
                // issue the next read
                if (iss_reg < count_reg)
                begin
                    dv_next  = 1'b1;
                    cmp_next = iss_reg[IW-1:0];
                    iss_next = iss_reg + CNT_W'(1);
                end
                // resolve the previous read
                if (dv_reg)
                begin
                    if (hit)
                    begin
                        done_next    = 1'b1;
                        allowed_next = rd_rule.allows;
                        matched_next = 1'b1;
                        idx_next     = fmipf_pkg::IDX_W'(cmp_reg);
                        state_next   = ST_IDLE;
                        dv_next      = 1'b0;
                    end
                    else if (last)
                    begin
                        done_next    = 1'b1;
                        allowed_next = 1'b1;
                        matched_next = 1'b0;
                        idx_next     = '0;
                        state_next   = ST_IDLE;
                        dv_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
            done_reg  <= done_next;
        end
    end

    // Payload and scan position
    always_ff @(posedge clk)
    begin
        iss_reg     <= iss_next;
        cmp_reg     <= cmp_next;
        qaddr_reg   <= qaddr_next;
        allowed_reg <= allowed_next;
        matched_reg <= matched_next;
        idx_reg     <= idx_next;
    end

    assign done          = done_reg;
    assign allowed       = allowed_reg;
    assign rule_matched  = matched_reg;
    assign matching_rule = idx_reg;

`ifndef ASSERT_OFF
    // Table fill never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RULE_CAPACITY))
        else $error("rule count above capacity");

    // A miss always permits and reports index zero
    a_miss_default: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !matched_reg |-> allowed_reg && (idx_reg == '0))
        else $error("miss result not default");

    // A scan only runs over a non-empty table
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> count_reg != '0)
        else $error("scan with empty table");

    // A compared rule index lies inside the filled table
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> CNT_W'(cmp_reg) < count_reg)
        else $error("compare index out of range");

    // No item is taken from the queue while a scan runs
    a_no_pop_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !pop)
        else $error("pop during scan");
`endif

endmodule

`default_nettype wire

// ===== design/first_match_ip_prefix_filter_top.sv =====
// Rule append: written to the table when the back end takes it from the queue; no result.
// Query: the back end reads the stored rules in order and compares each; done pulses
// on the first match, after the last rule on a miss, or straight from idle on an empty table.
// The back end takes no new item from the queue while a scan runs; busy rises when the
// two-entry queue is full. Results cannot be stalled. Reset (rst_n, async) empties the
// table. Uses fmipf_pkg and the fmipf_* modules.
`default_nettype none

module first_match_ip_prefix_filter_top #(
    parameter int RULE_CAPACITY = fmipf_pkg::RULE_CAPACITY
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           kind,
    input  wire logic                           rule_allows,
    input  wire logic [fmipf_pkg::ADDR_W-1:0]   address,
    input  wire logic [fmipf_pkg::LEN_W-1:0]    prefix_length,
    output logic                                done,
    output logic                                allowed,
    output logic                                rule_matched,
    output logic [fmipf_pkg::IDX_W-1:0]         matching_rule
);

    fmipf_pkg::cmd_t push_cmd;
    fmipf_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;

    // Accept and normalize items
    fmipf_front u_front (
        .start         (start),
        .kind          (kind),
        .rule_allows   (rule_allows),
        .address       (address),
        .prefix_length (prefix_length),
        .q_full        (q_full),
        .busy          (busy),
        .push          (push),
        .cmd           (push_cmd)
    );

    // Decouple front and back
    fmipf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Table update and first-match scan
    fmipf_back #(
        .RULE_CAPACITY (RULE_CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .done          (done),
        .allowed       (allowed),
        .rule_matched  (rule_matched),
        .matching_rule (matching_rule)
    );

endmodule

`default_nettype wire
